// File: rtl/irrw_pkg.sv
// ----------------------------------------------------------------------------
// irrw_pkg
// Shared types and codes for the interval resize and reorder window.
// ----------------------------------------------------------------------------
`default_nettype none

package irrw_pkg;

	localparam int CoordInW  = 31;
	localparam int CoordOutW = 33;
	localparam int ExpW      = 30;
	localparam int ModeW     = 4;
	localparam int StrandW   = 2;
	localparam int TagW      = 16;
	localparam int InDataW   = 88;
	localparam int OutDataW  = 88;

	// resize modes
	localparam logic [ModeW-1:0] MODE_NONE          = 4'd0;
	localparam logic [ModeW-1:0] MODE_SHRINK_START  = 4'd1;
	localparam logic [ModeW-1:0] MODE_SHRINK_END    = 4'd2;
	localparam logic [ModeW-1:0] MODE_SHRINK_5PRIME = 4'd3;
	localparam logic [ModeW-1:0] MODE_SHRINK_3PRIME = 4'd4;
	localparam logic [ModeW-1:0] MODE_EXPAND_START  = 4'd5;
	localparam logic [ModeW-1:0] MODE_EXPAND_END    = 4'd6;
	localparam logic [ModeW-1:0] MODE_EXPAND_5PRIME = 4'd7;
	localparam logic [ModeW-1:0] MODE_EXPAND_3PRIME = 4'd8;

	// strand codes
	localparam logic [StrandW-1:0] STRAND_PLUS  = 2'd1;
	localparam logic [StrandW-1:0] STRAND_MINUS = 2'd2;

	// configuration register indexes
	localparam logic REG_MODE      = 1'b0;
	localparam logic REG_EXPANSION = 1'b1;

	typedef struct packed {
		logic signed [CoordOutW-1:0] lo;
		logic signed [CoordOutW-1:0] hi;
		logic [StrandW-1:0]          strand;
		logic [TagW-1:0]             tag;
	} entry_t;

	typedef struct packed {
		logic pop;
		logic ins;
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

`default_nettype wire

// File: rtl/interval_resize_reorder_window.sv
// ----------------------------------------------------------------------------
// interval_resize_reorder_window
// Start-sorted interval stream: release by threshold, resize, sorted insert.
// ----------------------------------------------------------------------------
// Each accepted interval first releases, from the head of a window kept
// sorted by (start, end), every buffered interval whose end lies below the
// incoming start minus the expansion; if the window is still full, the head
// is forced out as well. The interval is then resized by resize_mode and
// strand (only when its resize_enabled flag is set) and inserted in sorted
// order, ties after equal keys. An item with the end-of-stream flag in tuser
// flushes the whole window. The window is a row of BUFFER_DEPTH cells, each
// holding one interval; a pop shifts every cell one place toward the head, an
// insert shifts the cells behind the insertion point one place toward the
// tail. An item is accepted, the intervals to be released then leave the head
// one by one, and the item is then inserted (a flush releases the whole window
// and inserts nothing); no new item is taken until this is done. Releases
// wait whenever the output register is still held by the sink. m_tlast marks
// the last result caused by one input item. Configuration writes are taken
// in any cycle and always ready; write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_resize_reorder_window
	import irrw_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// [30:0] interval_start, [61:31] interval_end, [63:62] interval_strand,
	// [64] resize_enabled, [80:65] interval_tag, [87:81] zero
	input  wire logic [InDataW-1:0]  s_tdata,
	// [0] end_of_stream
	input  wire logic                s_tuser,

	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// [32:0] out_start, [65:33] out_end, [67:66] out_strand,
	// [83:68] out_tag, [87:84] zero
	output logic [OutDataW-1:0]      m_tdata,
	// last_of_run
	output logic                     m_tlast,

	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [ExpW-1:0]     cfg_data
);

	localparam int OccW = $clog2(BUFFER_DEPTH + 1);

	// configuration
	logic [ModeW-1:0] mode_q;
	logic [ExpW-1:0]  exp_q;

	// control
	state_t        state_q;
	state_t        state_d;
	logic [OccW-1:0] occ_q;
	logic          eos_q;
	logic          done_q;
	logic          out_valid_q;
	logic          out_last_q;

	// held item
	entry_t                      new_q;
	logic signed [CoordOutW-1:0] thr_q;
	entry_t                      out_q;

	// resize datapath
	logic signed [CoordOutW-1:0] rs_lo;
	logic signed [CoordOutW-1:0] rs_hi;
	logic signed [CoordOutW-1:0] rs_thr;

	// cell row
	entry_t    cell_entry [BUFFER_DEPTH];
	logic      cell_ahead [BUFFER_DEPTH];
	logic      cell_valid [BUFFER_DEPTH];
	cell_cmd_t cmd;

	logic accept;
	logic out_free;
	logic have_occ;
	logic full;
	logic below0;
	logic below1;
	logic pop_want;
	logic pop_last;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0000, out_q.tag, out_q.strand, out_q.hi, out_q.lo};

	irrw_resize u_resize (
		.in_lo     (s_tdata[30:0]),
		.in_hi     (s_tdata[61:31]),
		.strand    (s_tdata[63:62]),
		.enabled   (s_tdata[64]),
		.mode      (mode_q),
		.expansion (exp_q),
		.out_lo    (rs_lo),
		.out_hi    (rs_hi),
		.thr       (rs_thr)
	);

	// head release decisions
	assign have_occ = (occ_q != '0);
	assign full     = (occ_q == OccW'(BUFFER_DEPTH));
	assign below0   = have_occ && (cell_entry[0].hi < thr_q);
	assign below1   = (occ_q > OccW'(1)) && (cell_entry[1].hi < thr_q);

	always_comb begin
		if (eos_q) begin
			pop_want = have_occ;
			pop_last = (occ_q == OccW'(1));
		end else begin
			pop_want = below0 || full;
			// a forced pop of a full window ends the releases for this item
			pop_last = below0 ? !below1 : 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (done_q || !pop_want) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_RUN: begin
				if (!done_q && pop_want) begin
					cmd.pop = out_free;
				end else begin
					cmd.ins = !eos_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			eos_q       <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			mode_q      <= MODE_NONE;
			exp_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:      mode_q <= cfg_data[ModeW-1:0];
					REG_EXPANSION: exp_q  <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				eos_q  <= s_tuser;
				done_q <= 1'b0;
			end
			if (cmd.pop) begin
				done_q      <= pop_last;
				occ_q       <= occ_q - OccW'(1);
				out_valid_q <= 1'b1;
				out_last_q  <= pop_last;
			end else begin
				if (m_tready) out_valid_q <= 1'b0;
				if (cmd.ins)  occ_q <= occ_q + OccW'(1);
			end
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.lo     <= rs_lo;
			new_q.hi     <= rs_hi;
			new_q.strand <= s_tdata[63:62];
			new_q.tag    <= s_tdata[80:65];
			thr_q        <= rs_thr;
		end
		if (cmd.pop) out_q <= cell_entry[0];
	end

	// row of cells; slot 0 is the head
	for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
		assign cell_valid[i] = (occ_q > OccW'(i));

		if (i == 0) begin : g_head
			irrw_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.new_entry   (new_q),
				.left_entry  (new_q),
				.left_valid  (1'b1),
				.left_ahead  (1'b0),
				.right_entry (cell_entry[1]),
				.valid       (cell_valid[0]),
				.entry       (cell_entry[0]),
				.ahead       (cell_ahead[0])
			);
		end else if (i == BUFFER_DEPTH - 1) begin : g_tail
			irrw_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.new_entry   (new_q),
				.left_entry  (cell_entry[i-1]),
				.left_valid  (cell_valid[i-1]),
				.left_ahead  (cell_ahead[i-1]),
				.right_entry (cell_entry[i]),
				.valid       (cell_valid[i]),
				.entry       (cell_entry[i]),
				.ahead       (cell_ahead[i])
			);
		end else begin : g_mid
			irrw_cell u_cell (
				.clk         (clk),
				.cmd         (cmd),
				.new_entry   (new_q),
				.left_entry  (cell_entry[i-1]),
				.left_valid  (cell_valid[i-1]),
				.left_ahead  (cell_ahead[i-1]),
				.right_entry (cell_entry[i+1]),
				.valid       (cell_valid[i]),
				.entry       (cell_entry[i]),
				.ahead       (cell_ahead[i])
			);
		end
	end

endmodule

`default_nettype wire

// File: rtl/irrw_resize.sv
// ----------------------------------------------------------------------------
// irrw_resize
// Reshapes one incoming interval by mode and strand; forms the release
// threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module irrw_resize
	import irrw_pkg::*;
(
	input  wire logic [CoordInW-1:0]         in_lo,
	input  wire logic [CoordInW-1:0]         in_hi,
	input  wire logic [StrandW-1:0]          strand,
	input  wire logic                        enabled,
	input  wire logic [ModeW-1:0]            mode,
	input  wire logic [ExpW-1:0]             expansion,
	output logic signed [CoordOutW-1:0]      out_lo,
	output logic signed [CoordOutW-1:0]      out_hi,
	output logic signed [CoordOutW-1:0]      thr
);

	logic signed [CoordOutW-1:0] lo0;
	logic signed [CoordOutW-1:0] hi0;
	logic signed [CoordOutW-1:0] ex;
	logic signed [CoordOutW-1:0] lo_exp;
	logic signed [CoordOutW-1:0] hi_exp;
	logic [ModeW-1:0]            eff_mode;
	logic                        plus;
	logic                        minus;

	assign lo0      = $signed({2'b00, in_lo});
	assign hi0      = $signed({2'b00, in_hi});
	assign ex       = $signed({3'b000, expansion});
	assign lo_exp   = lo0 - ex;
	assign hi_exp   = hi0 + ex;
	assign thr      = lo_exp;
	assign eff_mode = enabled ? mode : MODE_NONE;
	assign plus     = (strand == STRAND_PLUS);
	assign minus    = (strand == STRAND_MINUS);

	always_comb begin
		out_lo = lo0;
		out_hi = hi0;
		case (eff_mode)
			MODE_SHRINK_START: out_hi = lo0;
			MODE_SHRINK_END:   out_lo = hi0;
			MODE_SHRINK_5PRIME: begin
				if (plus)       out_hi = lo0;
				else if (minus) out_lo = hi0;
			end
			MODE_SHRINK_3PRIME: begin
				if (plus)       out_lo = hi0;
				else if (minus) out_hi = lo0;
			end
			MODE_EXPAND_START: out_lo = lo_exp;
			MODE_EXPAND_END:   out_hi = hi_exp;
			MODE_EXPAND_5PRIME: begin
				if (plus)       out_lo = lo_exp;
				else if (minus) out_hi = hi_exp;
			end
			MODE_EXPAND_3PRIME: begin
				if (plus)       out_hi = hi_exp;
				else if (minus) out_lo = lo_exp;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/irrw_cell.sv
// ----------------------------------------------------------------------------
// irrw_cell
// One slot of the sorted window: holds one interval, shifts toward the head
// on a pop and toward the tail on an insert ahead of it.
// ----------------------------------------------------------------------------
`default_nettype none

module irrw_cell
	import irrw_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_cmd_t cmd,
	input  wire entry_t    new_entry,
	input  wire entry_t    left_entry,
	input  wire logic      left_valid,
	input  wire logic      left_ahead,
	input  wire entry_t    right_entry,
	input  wire logic      valid,
	output entry_t         entry,
	output logic           ahead
);

	entry_t entry_q;

	assign entry = entry_q;

	// new interval sorts ahead of this slot; ties go behind
	assign ahead = valid &&
		((new_entry.lo < entry_q.lo) ||
		 ((new_entry.lo == entry_q.lo) && (new_entry.hi < entry_q.hi)));

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			entry_q <= right_entry;
		end else if (cmd.ins) begin
			if (ahead) begin
				entry_q <= left_ahead ? left_entry : new_entry;
			end else if (!valid && left_valid) begin
				// first free slot: take the shifted neighbor or the new interval
				entry_q <= left_ahead ? left_entry : new_entry;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/irrw_checker.sv
// ----------------------------------------------------------------------------
// irrw_checker
// Port-level checks for the interval resize and reorder window.
// ----------------------------------------------------------------------------
`default_nettype none

module irrw_checker
	import irrw_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OutDataW-1:0] m_tdata,
	input wire logic                m_tlast,
	input wire logic                cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// one item at a time: no request is taken right after another
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while an item is in work");

	// a new result appears only while an item is being worked
	a_out_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready)
		else $error("result appeared with no item in work");

	// configuration is not back-pressured while the block is idle
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> cfg_ready)
		else $error("configuration port stalled");

endmodule

bind interval_resize_reorder_window irrw_checker u_irrw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

// File: tb/sv/window_checker.sv
// ----------------------------------------------------------------------------
// window_checker
// Watches the interval, configuration and release channels of the window,
// predicts each released interval and compares it field by field.
// ----------------------------------------------------------------------------

module window_checker
	import irrw_pkg::*;
#(
	parameter int BUFFER_DEPTH = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	// [30:0] start, [61:31] end, [63:62] strand, [64] resize_enabled,
	// [80:65] tag, [87:81] zero
	input  wire logic [InDataW-1:0]  s_tdata,
	// [0] end_of_stream
	input  wire logic                s_tuser,
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	// [32:0] start, [65:33] end, [67:66] strand, [83:68] tag, [87:84] zero
	input  wire logic [OutDataW-1:0] m_tdata,
	// last_of_run
	input  wire logic                m_tlast,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [ExpW-1:0]     cfg_data,
	output int                       fail_count,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PrintCap = 40;

	typedef struct {
		longint           lo;
		longint           hi;
		logic [StrandW-1:0] strand;
		logic [TagW-1:0]    tag;
	} slot_t;

	typedef struct packed {
		logic [CoordOutW-1:0] lo;
		logic [CoordOutW-1:0] hi;
		logic [StrandW-1:0]   strand;
		logic [TagW-1:0]      tag;
		logic                 last;
	} release_t;

	logic [ModeW-1:0] cur_mode = MODE_NONE;
	logic [ExpW-1:0]  cur_expansion = '0;
	slot_t            window_q[$];
	release_t         release_q[$];
	int               mismatches = 0;
	int               outstanding = 0;
	int               result_no = 0;

	assign fail_count = mismatches;
	assign pending    = outstanding;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PrintCap)
			$display("mismatch: %s at result %0d: got %h, expected %h",
				what, result_no, got, want);
	endtask

	// move the head of the window into the list of expected releases
	function automatic void release_head();
		release_t r;
		r.lo     = window_q[0].lo[CoordOutW-1:0];
		r.hi     = window_q[0].hi[CoordOutW-1:0];
		r.strand = window_q[0].strand;
		r.tag    = window_q[0].tag;
		r.last   = 1'b0;
		release_q.insert(release_q.size(), r);
		window_q.delete(0);
	endfunction

	function automatic void predict_releases(input logic [InDataW-1:0] d, input logic eos);
		longint           s0, e0, ex, s, e, thr;
		logic [ModeW-1:0] mode;
		logic [StrandW-1:0] strand;
		int               base, pos;
		slot_t            slot;
		release_t         r;
		base = release_q.size();
		if (eos) begin
			while (window_q.size() > 0) release_head();
		end else begin
			s0     = longint'(d[30:0]);
			e0     = longint'(d[61:31]);
			strand = d[63:62];
			ex     = longint'(cur_expansion);
			mode   = d[64] ? cur_mode : MODE_NONE;
			thr    = s0 - ex;
			while (window_q.size() > 0 && window_q[0].hi < thr) release_head();
			// window still full: force the head out
			if (window_q.size() >= BUFFER_DEPTH) release_head();
			s = s0;
			e = e0;
			case (mode)
				MODE_SHRINK_START: e = s0;
				MODE_SHRINK_END:   s = e0;
				MODE_SHRINK_5PRIME: begin
					if (strand == STRAND_PLUS) e = s0;
					else if (strand == STRAND_MINUS) s = e0;
				end
				MODE_SHRINK_3PRIME: begin
					if (strand == STRAND_PLUS) s = e0;
					else if (strand == STRAND_MINUS) e = s0;
				end
				MODE_EXPAND_START: s = s0 - ex;
				MODE_EXPAND_END:   e = e0 + ex;
				MODE_EXPAND_5PRIME: begin
					if (strand == STRAND_PLUS) s = s0 - ex;
					else if (strand == STRAND_MINUS) e = e0 + ex;
				end
				MODE_EXPAND_3PRIME: begin
					if (strand == STRAND_PLUS) e = e0 + ex;
					else if (strand == STRAND_MINUS) s = s0 - ex;
				end
				default: ;
			endcase
			// ties go after equal keys
			pos = window_q.size();
			for (int i = 0; i < window_q.size(); i++) begin
				if (s < window_q[i].lo || (s == window_q[i].lo && e < window_q[i].hi)) begin
					pos = i;
					break;
				end
			end
			slot.lo     = s;
			slot.hi     = e;
			slot.strand = strand;
			slot.tag    = d[80:65];
			window_q.insert(pos, slot);
		end
		if (release_q.size() > base) begin
			r = release_q.pop_back();
			r.last = 1'b1;
			release_q.insert(release_q.size(), r);
		end
	endfunction

	always @(posedge clk) begin
		release_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MODE) cur_mode = cfg_data[ModeW-1:0];
				else cur_expansion = cfg_data;
			end
			if (s_tvalid && s_tready) predict_releases(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (release_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[63:0], '0);
				end else begin
					want = release_q[0];
					release_q.delete(0);
					if (m_tdata[32:0] !== want.lo)
						report_mismatch("out_start", m_tdata[32:0], want.lo);
					if (m_tdata[65:33] !== want.hi)
						report_mismatch("out_end", m_tdata[65:33], want.hi);
					if (m_tdata[67:66] !== want.strand)
						report_mismatch("out_strand", m_tdata[67:66], want.strand);
					if (m_tdata[83:68] !== want.tag)
						report_mismatch("out_tag", m_tdata[83:68], want.tag);
					if (m_tlast !== want.last)
						report_mismatch("last_of_run", m_tlast, want.last);
				end
				result_no++;
			end
		end
		outstanding <= release_q.size();
	end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the interval resize and reorder window: directed
// intervals for every resize mode and corner, then random start-sorted runs
// under many settings, with random stalls on both streams.
// ----------------------------------------------------------------------------

module testbench;
	import irrw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                  Depth       = 64;
	localparam int                  SettleTicks = 16;
	localparam int                  RandomItems = 450;
	localparam logic [CoordInW-1:0] CoordMax    = 31'h7FFF_FFFF;
	localparam logic [ExpW-1:0]     ExpMax      = 30'h3FFF_FFFF;
	localparam logic [StrandW-1:0]  STRAND_UNKNOWN  = 2'd0;
	localparam logic [StrandW-1:0]  STRAND_RESERVED = 2'd3;
	localparam logic [ModeW-1:0]    MODE_UNUSED_LO  = 4'd9;
	localparam logic [ModeW-1:0]    MODE_UNUSED_HI  = 4'd15;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// [30:0] start, [61:31] end, [63:62] strand, [64] resize_enabled,
	// [80:65] tag, [87:81] zero
	logic [InDataW-1:0]  s_tdata = '0;
	// [0] end_of_stream
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// [32:0] start, [65:33] end, [67:66] strand, [83:68] tag, [87:84] zero
	logic [OutDataW-1:0] m_tdata;
	// last_of_run
	logic                m_tlast;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_index = REG_MODE;
	logic [ExpW-1:0]     cfg_data = '0;
	int                  fail_count;
	int                  pending;

	// sender pacing: when set, requests follow back to back
	bit                  sender_burst = 1'b0;
	int                  sent_items = 0;
	// sink pacing state
	int                  stall_left = 0;
	int                  calm_left = 0;

	interval_resize_reorder_window #(.BUFFER_DEPTH(Depth)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	window_checker #(.BUFFER_DEPTH(Depth)) check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Sink pacing: mostly ready, short stalls, a few long ones, and calm
	// stretches where it never stalls.
	always @(posedge clk) begin
		int r;
		if (calm_left > 0) begin
			calm_left--;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3) calm_left = $urandom_range(20, 100);
			else if (r < 6) stall_left = $urandom_range(10, 40);
			else if (r < 30) stall_left = $urandom_range(1, 3);
			m_tready <= (stall_left == 0);
		end
	end

	function automatic logic [InDataW-1:0] pack_interval(input logic [CoordInW-1:0] s,
			input logic [CoordInW-1:0] e, input logic [StrandW-1:0] strand,
			input logic en, input logic [TagW-1:0] tag);
		return {7'b0, tag, en, strand, e, s};
	endfunction

	function automatic int sender_gap();
		int r;
		if (sender_burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one request and hold it until taken. Valid is left high so a
	// back-to-back request does not drop it; drop it only when a gap follows.
	task automatic send_item(input logic [InDataW-1:0] d, input logic eos);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= eos;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_items++;
	endtask

	task automatic send_interval(input logic [CoordInW-1:0] s, input logic [CoordInW-1:0] e,
			input logic [StrandW-1:0] strand, input logic en);
		send_item(pack_interval(s, e, strand, en, 16'($urandom())), 1'b0);
	endtask

	// Flush request; the other fields carry noise the block must ignore.
	task automatic send_flush();
		logic [InDataW-1:0] d;
		d = pack_interval(31'($urandom()), 31'($urandom()), 2'($urandom()),
			1'($urandom()), 16'($urandom()));
		send_item(d, 1'b1);
	endtask

	// Drop valid and hold until every expected release has come, then let
	// a pending insert finish.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SettleTicks) @(posedge clk);
	endtask

	// Write both registers back to back while the block is idle.
	task automatic set_config(input logic [ModeW-1:0] mode, input logic [ExpW-1:0] expansion);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data  <= {26'($urandom()), mode};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_EXPANSION;
		cfg_data  <= expansion;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ModeW-1:0] pick_mode();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return MODE_NONE;
		if (r == 9) return 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		return 4'($urandom_range(MODE_SHRINK_START, MODE_EXPAND_3PRIME));
	endfunction

	function automatic logic [ExpW-1:0] pick_expansion();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return '0;
		if (r < 60) return 30'($urandom_range(0, 64));
		if (r < 75) return ExpMax;
		return 30'($urandom());
	endfunction

	// One run of mostly start-sorted intervals with random content; a share
	// of noise (fully random or reversed intervals) and stray flushes.
	task automatic run_random_phase(input int count, input int step_max, input int len_max,
			input int flush_pct);
		logic [31:0]         cursor;
		logic [CoordInW-1:0] s, e;
		int                  r;
		cursor = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : 32'($urandom_range(0, 4096));
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < flush_pct) begin
				send_flush();
			end else if (r < flush_pct + 8) begin
				send_interval(31'($urandom()), 31'($urandom()), 2'($urandom()),
					1'($urandom()));
			end else begin
				cursor = cursor + 32'($urandom_range(0, step_max));
				s = cursor[CoordInW-1:0];
				e = s + 31'($urandom_range(0, len_max));
				// an occasional interval that ends before it starts
				if (r > 96) e = s - 31'($urandom_range(1, 50));
				send_interval(s, e, 2'($urandom()), ($urandom_range(0, 4) != 0));
			end
			// now and then hold until the block has drained
			if ($urandom_range(0, 99) < 2) wait_idle();
		end
	endtask

	initial begin
		int steps[4];
		int lens[4];
		steps = '{0, 4, 32, 1000};
		lens  = '{0, 8, 64, 5000};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// flush of an empty window gives nothing
		send_flush();
		set_config(MODE_NONE, '0);
		send_interval('0, '0, STRAND_PLUS, 1'b1);
		send_interval('0, '0, STRAND_PLUS, 1'b1);              // tie with the previous one
		send_interval(31'd5, 31'd3, STRAND_UNKNOWN, 1'b1);     // ends before it starts
		set_config(MODE_SHRINK_START, 30'd10);
		send_interval(31'd100, 31'd150, STRAND_PLUS, 1'b1);
		send_interval(31'd120, 31'd130, STRAND_MINUS, 1'b1);
		set_config(MODE_SHRINK_END, 30'd10);
		send_interval(31'd200, 31'd260, STRAND_PLUS, 1'b1);
		send_interval(31'd210, 31'd220, STRAND_MINUS, 1'b1);
		set_config(MODE_SHRINK_5PRIME, 30'd10);
		send_interval(31'd300, 31'd350, STRAND_PLUS, 1'b1);
		send_interval(31'd310, 31'd330, STRAND_MINUS, 1'b1);
		send_interval(31'd320, 31'd340, STRAND_UNKNOWN, 1'b1); // strand unknown: untouched
		set_config(MODE_SHRINK_3PRIME, 30'd10);
		send_interval(31'd400, 31'd450, STRAND_PLUS, 1'b1);
		send_interval(31'd410, 31'd440, STRAND_MINUS, 1'b1);
		send_interval(31'd415, 31'd445, STRAND_RESERVED, 1'b1);
		// largest expansion: start goes negative, end goes past 31 bits
		set_config(MODE_EXPAND_START, ExpMax);
		send_interval('0, 31'd10, STRAND_PLUS, 1'b1);
		send_interval(31'd5, 31'd20, STRAND_MINUS, 1'b0);      // resizing disabled
		set_config(MODE_EXPAND_END, ExpMax);
		send_interval(CoordMax, CoordMax, STRAND_PLUS, 1'b1);
		send_flush();
		set_config(MODE_EXPAND_5PRIME, 30'd7);
		send_interval(31'd1000, 31'd1100, STRAND_PLUS, 1'b1);
		send_interval(31'd1010, 31'd1020, STRAND_MINUS, 1'b1);
		send_interval(31'd1030, 31'd1040, STRAND_UNKNOWN, 1'b1);
		set_config(MODE_EXPAND_3PRIME, 30'd7);
		send_interval(31'd2000, 31'd2100, STRAND_PLUS, 1'b1);
		send_interval(31'd2010, 31'd2020, STRAND_MINUS, 1'b1);
		// modes with no meaning behave as none
		set_config(MODE_UNUSED_LO, 30'd3);
		send_interval(31'd3000, 31'd3100, STRAND_PLUS, 1'b1);
		set_config(MODE_UNUSED_HI, 30'd3);
		send_interval(31'd3010, 31'd3020, STRAND_MINUS, 1'b1);
		send_flush();

		// --- random ---
		// first a long run that never reaches its threshold, so the window fills
		// and the head is forced out
		set_config(MODE_EXPAND_START, ExpMax);
		run_random_phase(Depth + 30, 16, 16, 0);
		send_flush();
		while (sent_items < RandomItems) begin
			set_config(pick_mode(), pick_expansion());
			sender_burst = ($urandom_range(0, 3) == 0);
			run_random_phase($urandom_range(35, 65), steps[$urandom_range(0, 3)],
				lens[$urandom_range(0, 3)], ($urandom_range(0, 1) == 0) ? 0 : 3);
			sender_burst = 1'b0;
			if ($urandom_range(0, 9) < 7) send_flush();
		end
		send_flush();

		wait_idle();
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
